// ===== rtl/qalu_pkg.sv =====
package qalu_pkg;

	typedef enum logic [3:0] {
		CMD_MUL    = 4'd0,
		CMD_ADDSAT = 4'd1,
		CMD_SUBSAT = 4'd2,
		CMD_MIN    = 4'd3,
		CMD_MAX    = 4'd4,
		CMD_ABS    = 4'd5,
		CMD_NEG    = 4'd6,
		CMD_DIV    = 4'd7,
		CMD_SQRT   = 4'd8
	} cmd_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [63:0] operand_a_high;
		logic [63:0] operand_a_low;
		logic [63:0] operand_b_high;
		logic [63:0] operand_b_low;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQ_DIV,
		ST_SQ_ADD,
		ST_SQ_MUL,
		ST_FIN,
		ST_OUT
	} state_t;

	// operation of the shared datapath in the current cycle
	typedef enum logic [2:0] {
		U_NONE,
		U_LOAD,
		U_MUL_STEP,
		U_DIV_STEP,
		U_SQ_ADD,
		U_SQ_HALF,
		U_FIN
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic sq_div_start;
	} qalu_ctl_t;

	localparam logic [127:0] MAX_MAG = {1'b0, {127{1'b1}}};
	localparam int MUL_STEPS = 16;
	localparam int DIV_BITS = 192;

	function automatic logic [127:0] neg128(input logic [127:0] x);
		return 128'(~x + 128'd1);
	endfunction

	function automatic logic [127:0] mag128(input logic [127:0] x);
		return x[127] ? neg128(x) : x;
	endfunction

	function automatic logic [127:0] finish(input logic neg, input logic ovf,
		input logic [127:0] mag);
		logic [127:0] m;
		m = ovf ? MAX_MAG : mag;
		return (neg && m != '0) ? neg128(m) : m;
	endfunction

endpackage

// ===== rtl/qalu_datapath.sv =====
module qalu_datapath
	import qalu_pkg::*;
(
	input  logic         clk,
	input  qalu_ctl_t    ctl,
	input  in_word_t     in_word,
	output logic         mul_last,
	output logic         div_last,
	output logic [127:0] result
);

	logic [3:0]   cmd_q;
	logic [127:0] a_q, b_q;
	logic [127:0] am_q, dm_q;
	logic         neg_q, dz_q;
	logic [255:0] prod_q;
	logic [3:0]   mcnt_q;
	logic [127:0] rem_q;
	logic [191:0] num_q;
	logic [7:0]   dcnt_q;
	logic [127:0] y_q;
	logic [127:0] res_q;

	logic [31:0]  ma, mb;
	logic [63:0]  pp;
	logic [2:0]   psum;
	logic [128:0] rsh;
	logic [129:0] rdiff;
	logic         take;
	logic [127:0] qmag;
	logic         qovf;
	logic [127:0] addy;
	logic [6:0]   top;
	logic [6:0]   sh;

	assign mul_last = (mcnt_q == 4'(MUL_STEPS - 1));
	assign div_last = (dcnt_q == 8'(DIV_BITS - 1));
	assign result = res_q;

	// one 32x32 partial product per cycle
	always_comb begin
		ma = am_q[{mcnt_q[3:2], 5'd0} +: 32];
		mb = dm_q[{mcnt_q[1:0], 5'd0} +: 32];
		pp = 64'(ma) * 64'(mb);
		psum = {1'b0, mcnt_q[3:2]} + {1'b0, mcnt_q[1:0]};
	end

	// one quotient bit per cycle
	always_comb begin
		rsh = {rem_q, num_q[191]};
		rdiff = {1'b0, rsh} - {2'b0, dm_q};
		take = !rdiff[129];
	end

	always_comb begin
		qmag = num_q[127:0];
		qovf = num_q[191:127] != '0;
	end

	always_comb begin
		top = '0;
		for (int k = 0; k < 128; k++)
			if (a_q[k]) top = 7'(k);
		sh = 7'((8'(top) + 8'd64) >> 1);
	end

	always_comb begin
		logic [127:0] q, s;
		q = qovf ? MAX_MAG : qmag;
		s = 128'(y_q + q);
		if (!y_q[127] && !q[127] && s[127]) addy = MAX_MAG;
		else if (y_q[127] && q[127] && !s[127]) addy = neg128(MAX_MAG);
		else addy = s;
	end

	always_ff @(posedge clk) begin
		case (ctl.uop)
			U_LOAD: begin
				cmd_q <= in_word.command;
				a_q <= {in_word.operand_a_high, in_word.operand_a_low};
				b_q <= {in_word.operand_b_high, in_word.operand_b_low};
				am_q <= mag128({in_word.operand_a_high, in_word.operand_a_low});
				dm_q <= mag128({in_word.operand_b_high, in_word.operand_b_low});
				neg_q <= in_word.operand_a_high[63] ^ in_word.operand_b_high[63];
				dz_q <= {in_word.operand_b_high, in_word.operand_b_low} == '0;
				prod_q <= '0;
				mcnt_q <= '0;
				rem_q <= '0;
				num_q <= {in_word.operand_a_high[63] ?
					mag128({in_word.operand_a_high, in_word.operand_a_low}) :
					{in_word.operand_a_high, in_word.operand_a_low}, 64'd0};
				dcnt_q <= '0;
			end
			U_MUL_STEP: begin
				prod_q <= 256'(prod_q + (256'(pp) << {psum, 5'd0}));
				mcnt_q <= 4'(mcnt_q + 4'd1);
			end
			U_DIV_STEP: begin
				rem_q <= take ? rdiff[127:0] : rsh[127:0];
				num_q <= {num_q[190:0], take};
				dcnt_q <= 8'(dcnt_q + 8'd1);
			end
			U_SQ_ADD: begin
				// y + a/y; quotient is positive here
				y_q <= addy;
			end
			U_SQ_HALF: begin
				// y*0.5 as a shift, equal to bits 191..64 of y*2^63 for positive y
				y_q <= {1'b0, y_q[127:1]};
			end
			U_FIN: begin
				case (cmd_t'(cmd_q))
					CMD_MUL:
						res_q <= finish(neg_q, prod_q[255:191] != '0, prod_q[191:64]);
					CMD_DIV:
						res_q <= dz_q ? finish(a_q[127], 1'b1, '0) : finish(neg_q, qovf, qmag);
					CMD_SQRT: res_q <= y_q;
					default: res_q <= '0;
				endcase
			end
			default: ;
		endcase
		if (ctl.uop == U_LOAD) begin
			logic [127:0] a, b, s;
			a = {in_word.operand_a_high, in_word.operand_a_low};
			b = {in_word.operand_b_high, in_word.operand_b_low};
			case (cmd_t'(in_word.command))
				CMD_ADDSAT: begin
					s = 128'(a + b);
					res_q <= (!(a[127] ^ b[127]) && (a[127] ^ s[127])) ?
						finish(a[127], 1'b1, '0) : s;
				end
				CMD_SUBSAT: begin
					s = 128'(a - b);
					res_q <= ((a[127] ^ b[127]) && (a[127] ^ s[127])) ?
						finish(a[127], 1'b1, '0) : s;
				end
				CMD_MIN: res_q <= ($signed(b) < $signed(a)) ? b : a;
				CMD_MAX: res_q <= ($signed(a) < $signed(b)) ? b : a;
				CMD_ABS: res_q <= mag128(a);
				CMD_NEG: res_q <= neg128(a);
				default: res_q <= '0;
			endcase
			if (cmd_t'(in_word.command) == CMD_SQRT) y_q <= '0;
		end
		if (ctl.sq_div_start) begin
			// seed on first pass, then y is the previous result
			logic [127:0] y;
			y = (ctl.uop == U_NONE && y_q == '0) ? (128'd1 << sh) : y_q;
			y_q <= y;
			dm_q <= y;
			rem_q <= '0;
			num_q <= {a_q, 64'd0};
			dcnt_q <= '0;
		end
	end

endmodule

// ===== rtl/q63_64_saturating_fixed_alu.sv =====
// Add, sub, min, max, abs and negate register their result as the word is accepted;
// multiply: one 32x32 partial product per cycle, then finish;
// divide: one quotient bit per cycle on the shared 130-bit subtractor, then finish.
// Square root: NEWTON_STEPS Newton passes on the same divider, then finish.
// One word at a time; in_ready is low while a word is in flight, high again the cycle
// after the result is taken. Reset (arst_n low) clears the sequencer and output valid.
module q63_64_saturating_fixed_alu
	import qalu_pkg::*;
#(
	parameter int NEWTON_STEPS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int IW = $clog2(NEWTON_STEPS + 1);

	state_t        state_q, state_d;
	logic [IW-1:0] iter_q;
	qalu_ctl_t     ctl;
	logic          mul_last, div_last;
	logic [127:0]  result;
	logic          first_q;

	qalu_datapath u_dp (
		.clk(clk), .ctl(ctl), .in_word(in_data),
		.mul_last(mul_last), .div_last(div_last), .result(result)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_valid) begin
					case (cmd_t'(in_data.command))
						CMD_MUL: state_d = ST_MUL;
						CMD_DIV: state_d = ST_DIV;
						CMD_SQRT:
							state_d = ($signed({in_data.operand_a_high,
								in_data.operand_a_low}) > 0) ? ST_SQ_DIV : ST_OUT;
						default: state_d = ST_OUT;
					endcase
				end
			ST_MUL: if (mul_last) state_d = ST_FIN;
			ST_DIV: if (div_last) state_d = ST_FIN;
			ST_SQ_DIV: if (div_last) state_d = ST_SQ_ADD;
			ST_SQ_ADD: state_d = ST_SQ_MUL;
			ST_SQ_MUL: state_d = (iter_q == IW'(NEWTON_STEPS - 1)) ? ST_FIN : ST_SQ_DIV;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '{uop: U_NONE, sq_div_start: 1'b0};
		case (state_q)
			ST_IDLE: if (in_valid) ctl.uop = U_LOAD;
			ST_MUL: ctl.uop = U_MUL_STEP;
			ST_DIV: ctl.uop = U_DIV_STEP;
			ST_SQ_DIV: begin
				if (first_q) ctl.sq_div_start = 1'b1;
				else ctl.uop = U_DIV_STEP;
			end
			ST_SQ_ADD: ctl.uop = U_SQ_ADD;
			ST_SQ_MUL: ctl.uop = U_SQ_HALF;
			ST_FIN: ctl.uop = U_FIN;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) iter_q <= '0;
			else if (state_q == ST_SQ_MUL) iter_q <= IW'(iter_q + 1'b1);
			// load the divider before the quotient steps of each pass
			first_q <= (state_d == ST_SQ_DIV) && (state_q != ST_SQ_DIV);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = '{result_high: result[127:64], result_low: result[63:0]};

endmodule

// ===== rtl/qalu_checker.sv =====
module qalu_checker
	import qalu_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// one word in flight: no accept while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted twice");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready && !out_valid)
		else $error("no return to idle");

endmodule

bind q63_64_saturating_fixed_alu qalu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
